### hw/rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Types, constants and helpers for the rangefinder frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam int DIST_W      = 22;
    localparam int RAW_W       = 24;
    localparam int TICK_W      = 16;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;
    localparam logic [TICK_W-1:0] TICK_MAX  = '1;

    // mm / 10 as multiply by ceil(2^27 / 10), exact for 24-bit inputs
    localparam int               DIV_SHIFT = 27;
    localparam logic [RAW_W-1:0] DIV_RECIP = 24'hCC_CCCD;

    localparam logic [POS_W-1:0] POS_DIST_LO  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_DIST_MID = POS_W'(9);
    localparam logic [POS_W-1:0] POS_DIST_HI  = POS_W'(10);
    localparam logic [POS_W-1:0] POS_STATUS   = POS_W'(11);
    localparam logic [POS_W-1:0] POS_CKSUM    = POS_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        REG_HEADER  = 2'd0,
        REG_MARK    = 2'd1,
        REG_STATUS  = 2'd2,
        REG_TIMEOUT = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PHASE_HEADER  = 2'd0,
        PHASE_MARK    = 2'd1,
        PHASE_PAYLOAD = 2'd2,
        PHASE_CKSUM   = 2'd3
    } t_phase;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic              timed_out;
        logic              checksum_failed;
        logic              frame_accepted;
        logic [DIST_W-1:0] distance_cm;
    } t_result;

    function automatic logic [DIST_W-1:0] div10(input logic [RAW_W-1:0] mm);
        logic [2*RAW_W-1:0] prod;
        prod = (2*RAW_W)'(mm) * (2*RAW_W)'(DIV_RECIP);
        return DIST_W'(prod >> DIV_SHIFT);
    endfunction

endpackage

### hw/rtl/rangefinder_frame_parser.sv
// ----------------------------------------------------------------------------
// rangefinder_frame_parser
// Hunts serial rangefinder frames, checks the sum byte and tracks distance.
// ----------------------------------------------------------------------------
// Input stream: one request per received byte or per millisecond tick.
//   s_axis_tuser selects the kind (0 byte, 1 tick), s_axis_tdata the byte.
// Output stream: exactly one result per input request, in order:
//   distance in cm (-1 = out of range), frame good, frame bad, timed out.
// Config channel: register index and data, always ready; write only while
//   the block is idle. Indexes past the register list are ignored.
// The result is valid in the cycle after input accept. Throughput is one
//   request per cycle unless the receiver stalls, set by the single output
//   register; divide by ten is its own register off captured distance bytes.
// When the receiver stalls, the held result blocks s_axis_tready until it is
//   taken or the register frees in the same cycle.
// Reset: parser waits for a header, distance is -1, tick count is zero and
//   the registers return to header 0x57, mark 0x00, status 1, timeout 200.
// ----------------------------------------------------------------------------
module rangefinder_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [21:0] distance_cm, [22] frame_accepted, [23] checksum_failed,
    // [24] timed_out, [31:25] zero
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rfp_pkg::*;

    logic [7:0]        r_header;
    logic [7:0]        r_mark;
    logic [7:0]        r_valid_status;
    logic [TICK_W-1:0] r_timeout;

    t_phase            r_phase,  n_phase;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [7:0]        r_sum,    n_sum;
    logic [RAW_W-1:0]  r_raw_mm, n_raw_mm;
    logic [7:0]        r_status, n_status;
    logic [DIST_W-1:0] r_dist,   n_dist;
    logic [TICK_W-1:0] r_ticks,  n_ticks;
    logic [DIST_W-1:0] r_quot;

    t_result           r_out, n_out;
    logic              r_out_valid;

    logic              in_acc;
    logic [7:0]        c;
    logic              accepted, failed, late;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header       <= 8'h57;
            r_mark         <= 8'h00;
            r_valid_status <= 8'd1;
            r_timeout      <= TICK_W'(200);
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index[7:2] == 6'd0) begin
            unique case (t_reg_idx'(i_cfg_index[1:0]))
                REG_HEADER:  r_header       <= i_cfg_data[7:0];
                REG_MARK:    r_mark         <= i_cfg_data[7:0];
                REG_STATUS:  r_valid_status <= i_cfg_data[7:0];
                REG_TIMEOUT: r_timeout      <= i_cfg_data;
                default:     r_header       <= r_header;
            endcase
        end
    end

    // quotient settles well before the checksum byte arrives
    always_ff @(posedge i_clk) begin
        r_quot <= div10(r_raw_mm);
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_raw_mm = r_raw_mm;
        n_status = r_status;
        n_dist   = r_dist;
        n_ticks  = r_ticks;
        accepted = 1'b0;
        failed   = 1'b0;

        if (t_kind'(s_axis_tuser) == KIND_TICK) begin
            if (r_ticks != TICK_MAX) begin
                n_ticks = r_ticks + TICK_W'(1);
            end
        end else begin
            unique case (r_phase)
                PHASE_HEADER: begin
                    if (c == r_header) begin
                        n_sum   = c;
                        n_pos   = POS_W'(1);
                        n_phase = PHASE_MARK;
                    end
                end
                PHASE_MARK: begin
                    if (c == r_mark) begin
                        n_sum   = r_sum + c;
                        n_pos   = POS_W'(2);
                        n_phase = PHASE_PAYLOAD;
                    end else begin
                        n_pos   = '0;
                        n_phase = PHASE_HEADER;
                    end
                end
                PHASE_PAYLOAD: begin
                    priority if (r_pos == POS_DIST_LO) begin
                        n_raw_mm[7:0] = c;
                    end else if (r_pos == POS_DIST_MID) begin
                        n_raw_mm[15:8] = c;
                    end else if (r_pos == POS_DIST_HI) begin
                        n_raw_mm[23:16] = c;
                    end else if (r_pos == POS_STATUS) begin
                        n_status = c;
                    end
                    n_sum = r_sum + c;
                    n_pos = r_pos + POS_W'(1);
                    if (n_pos >= POS_CKSUM) begin
                        n_phase = PHASE_CKSUM;
                    end
                end
                PHASE_CKSUM: begin
                    if (c == r_sum) begin
                        accepted = 1'b1;
                        n_dist   = (r_status == r_valid_status) ? r_quot : DIST_NONE;
                        n_ticks  = '0;
                    end else begin
                        failed = 1'b1;
                    end
                    n_phase = PHASE_HEADER;
                    n_pos   = '0;
                    n_sum   = '0;
                end
                default: n_phase = PHASE_HEADER;
            endcase
        end

        late = n_ticks > r_timeout;
        if (late) begin
            n_dist = DIST_NONE;
        end

        n_out.distance_cm     = n_dist;
        n_out.frame_accepted  = accepted;
        n_out.checksum_failed = failed;
        n_out.timed_out       = late;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_HEADER;
            r_pos       <= '0;
            r_sum       <= '0;
            r_raw_mm    <= '0;
            r_status    <= '0;
            r_dist      <= DIST_NONE;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_sum       <= n_sum;
                r_raw_mm    <= n_raw_mm;
                r_status    <= n_status;
                r_dist      <= n_dist;
                r_ticks     <= n_ticks;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.frame_accepted && r_out.checksum_failed))
        else $error("good and bad frame flagged together");

    a_good_not_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_accepted) |-> !r_out.timed_out)
        else $error("timeout reported on a good frame");

    a_late_no_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.timed_out) |-> (r_out.distance_cm == DIST_NONE))
        else $error("distance kept after timeout");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PHASE_HEADER) |-> (r_pos == '0))
        else $error("byte position not cleared while hunting header");

endmodule
